>>> design/hrs_pkg.sv
// Package for horizontal run smearing: command record passed from the
// front end through the queue to the back end, and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package hrs_pkg;

  // Width of run counts and the min_run register
  localparam int CNT_W = 7;
  // Width of the pixel fields
  localparam int PIX_W = 8;
  // Register indexes of the configuration port
  localparam logic REG_MIN_RUN      = 1'b0;
  localparam logic REG_WHITE_BORDER = 1'b1;

  // One item's worth of result beats: a run of equal pixels plus at most one
  // single pixel, in the order given by run_first.
  typedef struct packed {
    logic [CNT_W-1:0] run_cnt;   // pixels in the run, may be zero
    logic             run_white; // run pixel color
    logic             run_first; // run goes out before the single pixel
    logic             has_single;
    logic             single_white;
    logic             row_end;   // mark the final beat of this command
  } hrs_cmd_t;

endpackage

>>> design/hrs_in_if.sv
// Input channel: one pixel of a row per beat.
// Depends on hrs_pkg for the pixel width.
`timescale 1ns / 1ps

interface hrs_in_if;
  logic                      valid;
  logic                      ready;
  logic [hrs_pkg::PIX_W-1:0] pixel_in;
  logic                      row_end_in;

  modport source (output valid, output pixel_in, output row_end_in, input ready);
  modport sink   (input valid, input pixel_in, input row_end_in, output ready);
endinterface

>>> design/hrs_out_if.sv
// Output channel: one released pixel per beat.
// Depends on hrs_pkg for the pixel width.
`timescale 1ns / 1ps

interface hrs_out_if;
  logic                      valid;
  logic                      ready;
  logic [hrs_pkg::PIX_W-1:0] pixel_out;
  logic                      row_end_out;
  logic                      run_last;

  modport source (output valid, output pixel_out, output row_end_out, output run_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end_out, input run_last,
                  output ready);
endinterface

>>> design/hrs_front.sv
// Front end: holds the configuration registers and the run state, and turns
// each accepted pixel into at most one command for the back end.
// Depends on hrs_pkg.
`timescale 1ns / 1ps

module hrs_front #(
  parameter int MAX_RUN = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [hrs_pkg::CNT_W-1:0] cfg_data,
  input  logic                      accept,
  input  logic [hrs_pkg::PIX_W-1:0] pixel_in,
  input  logic                      row_end_in,
  output logic                      push,
  output hrs_pkg::hrs_cmd_t         cmd
);

  localparam int CW = hrs_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_RUN);
  localparam logic [CW-1:0] MIN_SMEAR = CW'(2);

  logic [CW-1:0] min_run;
  logic          white_border;
  logic [CW-1:0] pending;
  logic          committed;
  logic          leading;

  logic [CW-1:0] pending_next;
  logic          committed_next;
  logic          leading_next;
  logic [CW-1:0] run_len;
  logic [CW-1:0] pending_inc;
  logic          white;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run      <= '0;
      white_border <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hrs_pkg::REG_MIN_RUN:      min_run      <= cfg_data;
        hrs_pkg::REG_WHITE_BORDER: white_border <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    white       = |pixel_in;
    run_len     = (min_run > MAX_LEN) ? MAX_LEN : min_run;
    pending_inc = pending + CW'(1);

    cmd              = '0;
    cmd.run_first    = 1'b1;
    cmd.row_end      = row_end_in;
    pending_next     = pending;
    committed_next   = committed;
    leading_next     = leading;

    priority if (run_len < MIN_SMEAR) begin
      // pass-through: flush anything held as white, then the pixel itself
      cmd.run_cnt      = pending;
      cmd.run_white    = 1'b1;
      cmd.has_single   = 1'b1;
      cmd.single_white = white;
      pending_next     = '0;
      committed_next   = 1'b0;
      if (!white) leading_next = 1'b0;
    end else if (!white) begin
      // black closes a short run as black
      cmd.run_cnt      = pending;
      cmd.run_white    = 1'b0;
      cmd.has_single   = 1'b1;
      cmd.single_white = 1'b0;
      pending_next     = '0;
      committed_next   = 1'b0;
      leading_next     = 1'b0;
    end else if ((white_border && leading) || committed) begin
      cmd.has_single   = 1'b1;
      cmd.single_white = 1'b1;
    end else if (pending_inc >= run_len) begin
      // run just reached its length: release all of it white
      cmd.run_cnt      = pending_inc;
      cmd.run_white    = 1'b1;
      pending_next     = '0;
      committed_next   = 1'b1;
    end else begin
      pending_next     = pending_inc;
    end

    if (row_end_in) begin
      // leftover run at row end takes the border color; follows any single
      if (pending_next != '0) begin
        cmd.run_cnt   = pending_next;
        cmd.run_white = white_border;
        cmd.run_first = 1'b0;
      end
      pending_next   = '0;
      committed_next = 1'b0;
      leading_next   = 1'b1;
    end
  end

  assign push = accept && ((cmd.run_cnt != '0) || cmd.has_single);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      committed <= 1'b0;
      leading   <= 1'b1;
    end else if (accept) begin
      pending   <= pending_next;
      committed <= committed_next;
      leading   <= leading_next;
    end
  end

endmodule

>>> design/hrs_queue.sv
// Command queue between front and back end, register based, power-of-two
// depth. Depends on hrs_pkg.
`timescale 1ns / 1ps

module hrs_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hrs_pkg::hrs_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output hrs_pkg::hrs_cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = PW + 1;

  hrs_pkg::hrs_cmd_t slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNTW-1:0]   fill;

  assign full       = (fill == CNTW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + CNTW'(1);
        2'b01:   fill <= fill - CNTW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/hrs_back.sv
// Back end: expands one command at a time into output beats, one per cycle
// while out_ready is high, loading the next command on the final beat of
// the current one or when idle. Depends on hrs_pkg.
`timescale 1ns / 1ps

module hrs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  hrs_pkg::hrs_cmd_t         head_cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hrs_pkg::PIX_W-1:0] pixel_out,
  output logic                      row_end_out,
  output logic                      run_last
);

  localparam int CW = hrs_pkg::CNT_W;

  logic [CW-1:0] run_left;
  logic          single_left;
  logic          run_first;
  logic          run_white;
  logic          single_white;
  logic          row_end;

  logic is_run;
  logic last;
  logic take;

  always_comb begin
    is_run = (run_left != '0) && (run_first || !single_left);
    last   = is_run ? ((run_left == CW'(1)) && !single_left) : (run_left == '0);
  end

  assign out_valid   = (run_left != '0) || single_left;
  assign pixel_out   = {hrs_pkg::PIX_W{is_run ? run_white : single_white}};
  assign row_end_out = row_end && last;
  assign run_last    = last;
  assign take        = out_valid && out_ready;
  assign pop         = head_valid && (!out_valid || (take && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left    <= '0;
      single_left <= 1'b0;
    end else if (pop) begin
      run_left    <= head_cmd.run_cnt;
      single_left <= head_cmd.has_single;
    end else if (take) begin
      if (is_run) run_left <= run_left - CW'(1);
      else        single_left <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      run_first    <= head_cmd.run_first;
      run_white    <= head_cmd.run_white;
      single_white <= head_cmd.single_white;
      row_end      <= head_cmd.row_end;
    end
  end

endmodule

>>> design/horizontal_run_smearing_top.sv
// Top level of horizontal run smearing: front end, command queue, back end.
// Depends on hrs_pkg, hrs_in_if, hrs_out_if, hrs_front, hrs_queue, hrs_back.
//
//   channel  | dir | payload                          | beat
//   ---------+-----+----------------------------------+---------------------------
//   in_ch    | in  | pixel_in[7:0], row_end_in        | one input pixel
//   out_ch   | out | pixel_out[7:0], row_end_out, run_last | one released pixel
//   cfg      | in  | cfg_we, cfg_index, cfg_data[6:0] | one register write
//
// Cycles: an input beat is taken every cycle while the command queue has room
// (QUEUE_DEPTH entries); the front end classifies it in that same cycle.
// The back end sends one output beat per cycle while out_ch.ready is high, so
// an input beat releases 0 to MAX_RUN pixels; output rate sets the throughput.
// Reset: synchronous, clears run state (start of row), registers and queue.
// Stalls: a stalled output holds its beat; input stalls only on a full queue.
`timescale 1ns / 1ps

module horizontal_run_smearing_top #(
  parameter int MAX_RUN     = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [hrs_pkg::CNT_W-1:0] cfg_data,
  hrs_in_if.sink                    in_ch,
  hrs_out_if.source                 out_ch
);

  logic              accept;
  logic              push;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  hrs_pkg::hrs_cmd_t cmd;
  hrs_pkg::hrs_cmd_t head_cmd;

  // take input whenever the queue can hold the command it may make
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the pixel and advance the run state
  hrs_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel_in   (in_ch.pixel_in),
    .row_end_in (in_ch.row_end_in),
    .push       (push),
    .cmd        (cmd)
  );

  // decouple input from bursts of released pixels
  hrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // expand commands into output beats
  hrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_out   (out_ch.pixel_out),
    .row_end_out (out_ch.row_end_out),
    .run_last    (out_ch.run_last)
  );

endmodule

>>> design/hrs_checker.sv
// Port-level checks for horizontal run smearing, attached by bind.
// Depends on horizontal_run_smearing_top and its channel interfaces.
`timescale 1ns / 1ps

module hrs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_out,
  input logic       row_end_out,
  input logic       run_last
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(run_last))
    else $error("stalled output beat changed");

  // released pixels are pure black or white
  a_binary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_out == 8'd0) || (pixel_out == 8'd255))
    else $error("released pixel not black or white");

  // the row's final pixel always closes its item
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end_out |-> run_last)
    else $error("row end on a beat that is not the item's last");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind horizontal_run_smearing_top hrs_checker u_hrs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_out   (out_ch.pixel_out),
  .row_end_out (out_ch.row_end_out),
  .run_last    (out_ch.run_last)
);

>>> verif/tb_horizontal_run_smearing_top.sv
// Self-checking testbench for horizontal_run_smearing_top: directed table plus random rows,
// each output pixel checked against a known row's expectation or a run-smearing predictor.
// Depends on hrs_pkg, hrs_in_if, hrs_out_if and the block itself.
`timescale 1ns / 1ps

module tb_horizontal_run_smearing_top;

  localparam int RUN_CAP   = 64;  // saturation point of min_run in the block
  localparam int DRAIN_CYC = 10;  // idle margin before a register write and at the end
  localparam int PHASE_LEN = 120; // random pixels per idling phase
  localparam int CFG_EVERY = 40;  // reprogram the block this often within a phase
  localparam int HOLD_CYC  = 300; // long receiver hold-off that backs up the queue
  localparam int REG_W     = hrs_pkg::CNT_W;
  localparam int PW        = hrs_pkg::PIX_W;

  // One released pixel as seen on the output channel
  typedef struct packed {
    logic [PW-1:0] pix;
    logic          row_end;
    logic          run_last;
  } pixel_beat_t;

  // One row of the directed table: either a register write or a pixel. Rows with
  // known_out set carry their own expectation: known_n beats of known_pix, the last
  // one marked with known_re and run_last.
  typedef struct {
    bit               is_cfg;
    logic             reg_idx;
    logic [REG_W-1:0] reg_val;
    logic [PW-1:0]    pix;
    logic             re;
    bit               known_out;
    int               known_n;
    logic [PW-1:0]    known_pix;
    logic             known_re;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [REG_W-1:0] cfg_data;

  hrs_in_if  in_ch ();
  hrs_out_if out_ch ();

  horizontal_run_smearing_top #(
    .MAX_RUN (RUN_CAP)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: register copies and the run tracking of one row
  logic [REG_W-1:0] min_run_q;
  logic             white_border_q;
  int               pend_whites;
  bit               run_done;
  bit               at_row_start;

  pixel_beat_t released_q[$];   // pixels the block still owes, oldest first
  pixel_beat_t step_beats[$];   // pixels released by the pixel just predicted
  dir_row_t    directed_rows[$];

  int  fail_count;
  int  src_idle_pct;
  int  sink_idle_pct;
  bit  long_hold_req;

  // Random row shaping
  int  run_left;
  int  row_left;
  bit  cur_white;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Append n pixels of one color to the beats of the current step.
  function automatic void release_pixels(int n, logic [PW-1:0] pix);
    pixel_beat_t b;
    b.pix      = pix;
    b.row_end  = 1'b0;
    b.run_last = 1'b0;
    for (int i = 0; i < n; i++) step_beats.push_back(b);
  endfunction

  // Work out what one accepted pixel releases; leaves the beats in step_beats.
  function automatic void smear_step(logic [PW-1:0] pix_in, logic row_end_in);
    int  run_len;
    bit  is_white;
    is_white = (pix_in != '0);
    run_len  = (int'(min_run_q) > RUN_CAP) ? RUN_CAP : int'(min_run_q);
    step_beats.delete();

    if (run_len < 2) begin
      // smoothing off: flush anything held from an earlier setting as white
      release_pixels(pend_whites, 8'hFF);
      pend_whites = 0;
      run_done    = 1'b0;
      release_pixels(1, is_white ? 8'hFF : 8'h00);
      if (!is_white) at_row_start = 1'b0;
    end else if (!is_white) begin
      // black closes a short run: held whites go out black
      release_pixels(pend_whites, 8'h00);
      release_pixels(1, 8'h00);
      pend_whites  = 0;
      run_done     = 1'b0;
      at_row_start = 1'b0;
    end else if (white_border_q && at_row_start) begin
      release_pixels(1, 8'hFF);
    end else if (run_done) begin
      release_pixels(1, 8'hFF);
    end else begin
      pend_whites++;
      if (pend_whites >= run_len) begin
        release_pixels(pend_whites, 8'hFF);
        pend_whites = 0;
        run_done    = 1'b1;
      end
    end

    if (row_end_in) begin
      // trailing run takes the border color, then back to start of row
      release_pixels(pend_whites, white_border_q ? 8'hFF : 8'h00);
      pend_whites  = 0;
      run_done     = 1'b0;
      at_row_start = 1'b1;
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].row_end = 1'b1;
    end

    if (step_beats.size() > 0) step_beats[step_beats.size()-1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_cfg(logic idx, logic [REG_W-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pix(logic [PW-1:0] pix, logic re);
    dir_row_t r;
    r = '{default: '0};
    r.pix = pix;
    r.re  = re;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_known(logic [PW-1:0] pix, logic re, int n,
                                    logic [PW-1:0] epix, logic ere);
    dir_row_t r;
    r = '{default: '0};
    r.pix       = pix;
    r.re        = re;
    r.known_out = 1'b1;
    r.known_n   = n;
    r.known_pix = epix;
    r.known_re  = ere;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------
  // Write one register once the block has nothing left to release.
  task automatic write_reg(logic idx, logic [REG_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (released_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hrs_pkg::REG_MIN_RUN) min_run_q = val;
    else white_border_q = val[0];
  endtask

  // Offer one pixel, wait for the beat to be taken, then record what it releases.
  task automatic send_pixel(logic [PW-1:0] pix, logic re, bit known_out = 1'b0,
                            int known_n = 0, logic [PW-1:0] known_pix = '0,
                            logic known_re = 1'b0);
    pixel_beat_t b;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pixel_in   <= pix;
    in_ch.row_end_in <= re;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    smear_step(pix, re);
    if (known_out) begin
      for (int i = 0; i < known_n; i++) begin
        b.pix      = known_pix;
        b.row_end  = (i == known_n - 1) ? known_re : 1'b0;
        b.run_last = (i == known_n - 1);
        released_q.push_back(b);
      end
    end else begin
      foreach (step_beats[i]) released_q.push_back(step_beats[i]);
    end
  endtask

  // Pick a new setting; forced_len < 0 means a random min_run.
  task automatic reprogram(int forced_len);
    logic [REG_W-1:0] len;
    if (forced_len >= 0) len = REG_W'(forced_len);
    else begin
      case ($urandom_range(0, 7))
        0:       len = REG_W'(0);
        1:       len = REG_W'(1);
        2:       len = REG_W'(RUN_CAP);
        3:       len = REG_W'(127);
        4:       len = REG_W'($urandom_range(0, 127));
        default: len = REG_W'($urandom_range(2, 8));
      endcase
    end
    write_reg(hrs_pkg::REG_MIN_RUN, len);
    // upper bits are don't-care for the border flag; drive them at random
    write_reg(hrs_pkg::REG_WHITE_BORDER, REG_W'($urandom_range(0, 127)));
  endtask

  // Random rows: mostly alternating black and white runs sized around min_run,
  // with some pure noise pixels and stray row ends mixed in. With with_hold set,
  // ask the receiver for its long hold-off once the sender is streaming.
  task automatic random_phase(int first_len, bit with_hold);
    int            eff;
    logic [PW-1:0] pix;
    logic          re;
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (i % CFG_EVERY == 0) reprogram(i == 0 ? first_len : -1);
      if (with_hold && i == 1) long_hold_req = 1'b1;
      eff = (int'(min_run_q) > RUN_CAP) ? RUN_CAP : int'(min_run_q);
      if (eff < 1) eff = 1;
      if ($urandom_range(0, 9) == 0) begin
        pix = 8'($urandom_range(0, 255));
        re  = ($urandom_range(0, 7) == 0);
      end else begin
        if (run_left == 0) begin
          cur_white = !cur_white;
          run_left  = cur_white ? $urandom_range(1, eff + 2) : $urandom_range(1, 3);
        end
        if (row_left == 0) row_left = $urandom_range(1, 3 * eff + 8);
        pix = cur_white ? 8'($urandom_range(1, 255)) : 8'h00;
        run_left--;
        row_left--;
        re = (row_left == 0);
      end
      send_pixel(pix, re);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        // hold ready low while the sender keeps offering, so the queue fills
        for (int k = 0; k < HOLD_CYC; k++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each output beat with the oldest owed pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (released_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: pix=%02h row_end=%0b run_last=%0b",
                   out_ch.pixel_out, out_ch.row_end_out, out_ch.run_last);
      end else begin
        want = released_q.pop_front();
        if (out_ch.pixel_out !== want.pix || out_ch.row_end_out !== want.row_end ||
            out_ch.run_last !== want.run_last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp pix=%02h row_end=%0b run_last=%0b, got pix=%02h %s%0b %s%0b",
                     want.pix, want.row_end, want.run_last, out_ch.pixel_out,
                     "row_end=", out_ch.row_end_out, "run_last=", out_ch.run_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= hrs_pkg::REG_MIN_RUN;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.pixel_in   <= '0;
    in_ch.row_end_in <= 1'b0;
    fail_count     = 0;
    long_hold_req  = 1'b0;
    src_idle_pct   = 18;
    sink_idle_pct  = 56;
    min_run_q      = '0;
    white_border_q = 1'b0;
    pend_whites    = 0;
    run_done       = 1'b0;
    at_row_start   = 1'b1;
    run_left       = 0;
    row_left       = 0;
    cur_white      = 1'b0;

    // Out of reset smoothing is off: pixels pass one for one, gray maps to white.
    add_known(8'h00, 1'b0, 1, 8'h00, 1'b0);
    add_known(8'hFF, 1'b0, 1, 8'hFF, 1'b0);
    add_known(8'h01, 1'b1, 1, 8'hFF, 1'b1);
    // Runs shorter than three are smeared black, runs of three or more commit white.
    add_cfg(hrs_pkg::REG_MIN_RUN, 7'd3);
    add_known(8'h80, 1'b0, 0, 8'h00, 1'b0);
    add_known(8'h00, 1'b0, 2, 8'h00, 1'b0);
    add_known(8'hFF, 1'b0, 0, 8'h00, 1'b0);
    add_known(8'h7F, 1'b0, 0, 8'h00, 1'b0);
    add_known(8'h01, 1'b0, 3, 8'hFF, 1'b0);
    add_known(8'h40, 1'b0, 1, 8'hFF, 1'b0);
    add_known(8'h00, 1'b0, 1, 8'h00, 1'b0);
    add_known(8'hAA, 1'b0, 0, 8'h00, 1'b0);
    // short trailing run with a black border goes out black on the row end
    add_known(8'h55, 1'b1, 2, 8'h00, 1'b1);
    // White border, min_run beyond the cap: leading whites pass, trailing stays white.
    add_cfg(hrs_pkg::REG_WHITE_BORDER, 7'd1);
    add_cfg(hrs_pkg::REG_MIN_RUN, 7'd127);
    add_known(8'hFF, 1'b0, 1, 8'hFF, 1'b0);
    add_known(8'h00, 1'b0, 1, 8'h00, 1'b0);
    add_known(8'h02, 1'b0, 0, 8'h00, 1'b0);
    add_known(8'h04, 1'b0, 0, 8'h00, 1'b0);
    add_known(8'h08, 1'b1, 3, 8'hFF, 1'b1);
    add_known(8'h00, 1'b0, 1, 8'h00, 1'b0);
    add_pix(8'h10, 1'b0);
    add_pix(8'h20, 1'b0);
    add_pix(8'h40, 1'b0);
    // lower min_run mid-run: the next white finds the run long enough
    add_cfg(hrs_pkg::REG_MIN_RUN, 7'd2);
    add_pix(8'h80, 1'b0);
    add_pix(8'h00, 1'b0);
    add_pix(8'hFF, 1'b0);
    // switch smoothing off with a white held back: it is flushed white first
    add_cfg(hrs_pkg::REG_WHITE_BORDER, 7'd0);
    add_cfg(hrs_pkg::REG_MIN_RUN, 7'd1);
    add_pix(8'h00, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_pixel(directed_rows[i].pix, directed_rows[i].re, directed_rows[i].known_out,
                   directed_rows[i].known_n, directed_rows[i].known_pix,
                   directed_rows[i].known_re);
    end

    // Sender idles lightly, receiver heavily.
    random_phase(-1, 1'b0);

    // Swap: sender idles heavily, receiver lightly; open at the full run length.
    src_idle_pct  = 56;
    sink_idle_pct = 18;
    random_phase(RUN_CAP, 1'b0);

    // No idling on either side; open in pass-through so every pixel queues a
    // command, and hold the receiver off long enough to back the block up.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_phase(1, 1'b1);

    // Drop valid and let every owed pixel come out, then watch for strays.
    in_ch.valid <= 1'b0;
    while (released_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC * 2) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_horizontal_run_smearing_top: PASS");
    end else begin
      $display("tb_horizontal_run_smearing_top: FAIL");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_horizontal_run_smearing_top: FAIL");
    $finish;
  end

endmodule

>>> files.f
design/hrs_pkg.sv
design/hrs_in_if.sv
design/hrs_out_if.sv
design/hrs_front.sv
design/hrs_queue.sv
design/hrs_back.sv
design/horizontal_run_smearing_top.sv
design/hrs_checker.sv
verif/tb_horizontal_run_smearing_top.sv
